>>> rtl/ntc_pkg.sv
// Shared types and constants for the numeric token classifier.
// No dependencies; imported by every module of the block.
package ntc_pkg;

    // Width of the signed integer range that values saturate to.
    localparam int INT_BITS = 32;
    localparam int ACC_W    = INT_BITS + 4;

    // Depth of the character queue and of the result queue.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [ACC_W-1:0] MAG_HALF = ACC_W'(1) << (INT_BITS - 1);
    localparam logic [ACC_W-1:0] MAG_POS  = MAG_HALF - ACC_W'(1);

    localparam logic [1:0] CLASS_INT   = 2'd0;
    localparam logic [1:0] CLASS_REAL  = 2'd1;
    localparam logic [1:0] CLASS_IDENT = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_LO_A  = 8'h61;
    localparam logic [7:0] CHR_LO_Z  = 8'h7a;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHR_PLUS  = 8'h2b;
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_POINT = 8'h2e;
    localparam logic [7:0] CHR_UNDER = 8'h5f;
    localparam logic [7:0] CHR_LO_E  = 8'h65;
    localparam logic [7:0] CHR_UP_E  = 8'h45;

    typedef enum logic [3:0] {
        PH_START,
        PH_SIGN,
        PH_INT,
        PH_POINT0,
        PH_FRAC,
        PH_EXP_START,
        PH_EXP_SIGN,
        PH_EXP_DIG,
        PH_IDENT,
        PH_OTHER
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         token_class;
        logic signed [31:0] int_value;
        logic               int_overflow;
    } out_item_t;

    // Decoded character as it travels from the front to the back.
    typedef struct packed {
        logic       is_digit;
        logic       is_alpha;
        logic       is_sign;
        logic       is_minus;
        logic       is_point;
        logic       is_exp;
        logic       is_under;
        logic [3:0] digit;
        logic       last;
    } chr_info_t;

endpackage

>>> rtl/numeric_token_classifier_core.sv
// Top level of the numeric token classifier: front decoder, back phase machine.
// Depends on ntc_pkg, ntc_front and ntc_back.
//
// Takes one token character per cycle unless full and, on the character marked
// last, queues one result: integer, real, identifier or other string, plus the
// saturated signed value for integers. Characters are decoded into the two-entry
// character queue and taken by the phase machine while the result queue has
// room; the ports show the head of the result queue. Throughput is one character
// per cycle while the result queue has room, set by the phase machine and its
// single shift-add accumulator step. A pop held low first fills the two-entry
// result queue, then the character queue, and only then raises full.
module numeric_token_classifier_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ntc_pkg::in_item_t  token_char,
    output logic               empty,
    input  logic               pop,
    output ntc_pkg::out_item_t result
);
    import ntc_pkg::*;

    logic      chr_valid;
    logic      chr_take;
    chr_info_t chr_head;

    ntc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .token_char (token_char),
        .chr_valid  (chr_valid),
        .chr_head   (chr_head),
        .chr_take   (chr_take)
    );

    ntc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .chr_head  (chr_head),
        .chr_take  (chr_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> rtl/ntc_front.sv
// Front end: accepts characters, decodes them and queues the decoded form.
// Depends on ntc_pkg.
module ntc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ntc_pkg::in_item_t  token_char,
    output logic               chr_valid,
    output ntc_pkg::chr_info_t chr_head,
    input  logic               chr_take
);
    import ntc_pkg::*;

    chr_info_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    chr_info_t          info;
    logic               wr_en;
    logic [7:0]         c;

    always_comb
    begin
        c = token_char.char_code;
        info.is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
        info.is_alpha = ((c >= CHR_LO_A) && (c <= CHR_LO_Z)) ||
                        ((c >= CHR_UP_A) && (c <= CHR_UP_Z));
        info.is_sign  = (c == CHR_PLUS) || (c == CHR_MINUS);
        info.is_minus = (c == CHR_MINUS);
        info.is_point = (c == CHR_POINT);
        info.is_exp   = (c == CHR_LO_E) || (c == CHR_UP_E);
        info.is_under = (c == CHR_UNDER);
        info.digit    = c[3:0];
        info.last     = token_char.last_char;
    end

    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign wr_en     = push && !full;
    assign chr_valid = (cnt_reg != '0);
    assign chr_head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (chr_take)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (wr_en && !chr_take)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (!wr_en && chr_take)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= info;
        end
    end

endmodule

>>> rtl/ntc_back.sv
// Back end: token phase machine, saturating decimal accumulator and result queue.
// Depends on ntc_pkg.
module ntc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               chr_valid,
    input  ntc_pkg::chr_info_t chr_head,
    output logic               chr_take,
    output logic               empty,
    input  logic               pop,
    output ntc_pkg::out_item_t result
);
    import ntc_pkg::*;

    phase_t                phase_reg, phase_next, phase_step;
    logic                  neg_reg, neg_next, neg_upd;
    logic [INT_BITS-1:0]   acc_reg, acc_next, acc_upd;
    logic                  sat_reg, sat_next, sat_upd;
    logic [ACC_W-1:0]      scaled, lim;
    logic                  digit_step;
    logic [INT_BITS-1:0]   val;
    out_item_t             res_item;
    logic                  res_push;

    out_item_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                  res_full;
    logic                  res_pop;

    assign res_full = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign chr_take = chr_valid && !res_full;
    assign res_push = chr_take && chr_head.last;

    // Phase transition for the head character.
    always_comb
    begin
        case (phase_reg)
            PH_START:
            begin
                if (chr_head.is_sign)
                    phase_step = PH_SIGN;
                else if (chr_head.is_digit)
                    phase_step = PH_INT;
                else if (chr_head.is_point)
                    phase_step = PH_POINT0;
                else if (chr_head.is_alpha || chr_head.is_under)
                    phase_step = PH_IDENT;
                else
                    phase_step = PH_OTHER;
            end
            PH_SIGN:
            begin
                if (chr_head.is_digit)
                    phase_step = PH_INT;
                else if (chr_head.is_point)
                    phase_step = PH_POINT0;
                else
                    phase_step = PH_OTHER;
            end
            PH_INT:
            begin
                if (chr_head.is_digit)
                    phase_step = PH_INT;
                else if (chr_head.is_point)
                    phase_step = PH_FRAC;
                else if (chr_head.is_exp)
                    phase_step = PH_EXP_START;
                else
                    phase_step = PH_OTHER;
            end
            PH_POINT0:
            begin
                phase_step = chr_head.is_digit ? PH_FRAC : PH_OTHER;
            end
            PH_FRAC:
            begin
                if (chr_head.is_digit)
                    phase_step = PH_FRAC;
                else if (chr_head.is_exp)
                    phase_step = PH_EXP_START;
                else
                    phase_step = PH_OTHER;
            end
            PH_EXP_START:
            begin
                if (chr_head.is_sign)
                    phase_step = PH_EXP_SIGN;
                else if (chr_head.is_digit)
                    phase_step = PH_EXP_DIG;
                else
                    phase_step = PH_OTHER;
            end
            PH_EXP_SIGN, PH_EXP_DIG:
            begin
                phase_step = chr_head.is_digit ? PH_EXP_DIG : PH_OTHER;
            end
            PH_IDENT:
            begin
                phase_step = (chr_head.is_alpha || chr_head.is_digit || chr_head.is_under)
                             ? PH_IDENT : PH_OTHER;
            end
            default:
            begin
                phase_step = PH_OTHER;
            end
        endcase
    end

    // Next state: hold when no character is taken, return to start after the final character.
    always_comb
    begin
        if (!chr_take)
            phase_next = phase_reg;
        else if (chr_head.last)
            phase_next = PH_START;
        else
            phase_next = phase_step;
    end

    // Accumulator, sign and result for the head character.
    always_comb
    begin
        digit_step = chr_take && chr_head.is_digit &&
                     ((phase_reg == PH_START) || (phase_reg == PH_SIGN) ||
                      (phase_reg == PH_INT));
        neg_upd = (chr_take && (phase_reg == PH_START) && chr_head.is_sign)
                  ? chr_head.is_minus : neg_reg;
        lim     = neg_reg ? MAG_HALF : MAG_POS;
        scaled  = ({{4{1'b0}}, acc_reg} << 3) + ({{4{1'b0}}, acc_reg} << 1)
                  + ACC_W'(chr_head.digit);
        acc_upd = acc_reg;
        sat_upd = sat_reg;
        if (digit_step && !sat_reg)
        begin
            if (scaled > lim)
            begin
                acc_upd = lim[INT_BITS-1:0];
                sat_upd = 1'b1;
            end
            else
            begin
                acc_upd = scaled[INT_BITS-1:0];
            end
        end

        val = neg_upd ? (INT_BITS'(0) - acc_upd) : acc_upd;
        res_item.int_value    = '0;
        res_item.int_overflow = 1'b0;
        case (phase_step)
            PH_INT:
            begin
                res_item.token_class  = CLASS_INT;
                res_item.int_value    = 32'($signed(val));
                res_item.int_overflow = sat_upd;
            end
            PH_FRAC, PH_EXP_DIG:
            begin
                res_item.token_class = CLASS_REAL;
            end
            PH_IDENT:
            begin
                res_item.token_class = CLASS_IDENT;
            end
            default:
            begin
                res_item.token_class = CLASS_OTHER;
            end
        endcase

        if (res_push)
        begin
            neg_next = 1'b0;
            acc_next = '0;
            sat_next = 1'b0;
        end
        else
        begin
            neg_next = neg_upd;
            acc_next = acc_upd;
            sat_next = sat_upd;
        end
    end

    // Result queue.
    assign empty   = (cnt_reg == '0);
    assign res_pop = pop && !empty;
    assign result  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (res_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (res_push && !res_pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (!res_push && res_pop)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

>>> rtl/ntc_checker.sv
// Port-level checks for numeric_token_classifier_core, attached by bind.
// Depends on ntc_pkg.
module ntc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input ntc_pkg::in_item_t  token_char,
    input logic               empty,
    input logic               pop,
    input ntc_pkg::out_item_t result
);
    import ntc_pkg::*;

    // No result may be visible while in reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result visible during reset");

    // Only integer results carry a value or an overflow mark.
    a_non_int_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.token_class != CLASS_INT)
        |-> (result.int_value == 32'sd0 && !result.int_overflow))
        else $error("non-integer result carries a value");

    a_ovf_is_int: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.int_overflow) |-> (result.token_class == CLASS_INT))
        else $error("overflow set on non-integer result");

    // Hold a waiting result until it is popped.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before transfer");

endmodule

bind numeric_token_classifier_core ntc_checker u_ntc_checker (.*);
